// ===== sv/gwch_pkg.sv =====
// ----------------------------------------------------------------------------
// gwch_pkg
// shared types and constants for the gift-wrapping convex hull engine
// ----------------------------------------------------------------------------
package gwch_pkg;

	localparam int COORD_W  = 16;
	localparam int STATUS_W = 2;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_LOAD,
		S_DECIDE,
		S_LM_RD,
		S_LM_CMP,
		S_CAND_RD,
		S_CAND_LD,
		S_PT_RD,
		S_PT_DIFF,
		S_PT_MUL1,
		S_PT_MUL2,
		S_PT_CMP,
		S_EMIT
	} state_t;

endpackage

// ===== sv/gift_wrap_convex_hull_top.sv =====
// ----------------------------------------------------------------------------
// gift_wrap_convex_hull_top
// jarvis march convex hull: stores points, then walks and streams hull vertices
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                       | tuser      | tlast
//  ---------+-----+-----------------------------+------------+--------------
//  s_*      | in  | [15:0] x_coord [31:16] y    | -          | final_point
//  m_*      | out | [15:0] hull_x [31:16] hull_y| [1:0] status | last_of_run
//
//  a point transfer is taken whenever it is offered while the block is loading
//  the final point starts the walk; s_tready stays low until the run's last
//  result sits in the output register
//  leftmost search: each stored point is read, then compared (one ram read port)
//  each hull vertex: candidate read and load, then per stored point a read,
//  differences, two passes through the shared multiplier and a compare; the
//  vertex then goes to the output register, held back while that is full and m_tready is low
//  arst_n clears the sequencer, point count and overflow flag; the point
//  store is not cleared, only entries of the current set are ever read
//
module gift_wrap_convex_hull_top #(
	parameter int MAX_POINTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// point input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] x_coord, [31:16] y_coord
	input  logic        s_tlast,   // final_point
	// hull vertex output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] hull_x, [31:16] hull_y
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last_of_run
);

	import gwch_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// sequencer state
	state_t state_q, state_d;

	// control registers
	logic [CW-1:0] count_q;      // points held in the current set
	logic          overflow_q;   // a point was dropped on a full store
	logic [CW-1:0] idx_q;        // scan index over stored points
	logic [CW-1:0] emit_cnt_q;   // vertices already emitted in this walk
	logic [AW-1:0] start_idx_q;
	logic [AW-1:0] cur_idx_q;
	logic [AW-1:0] cand_idx_q;

	// datapath registers
	logic [COORD_W-1:0]       cur_x_q, cur_y_q;
	logic [COORD_W-1:0]       cand_x_q, cand_y_q;
	logic [COORD_W-1:0]       pt_x_q, pt_y_q;
	logic signed [DIFF_W-1:0] dxi_q, dyi_q, dxk_q, dyk_q;
	logic signed [PROD_W-1:0] prod_q, p1_q;

	// output register
	logic                out_valid_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q;
	logic [STATUS_W-1:0] out_st_q;
	logic                out_last_q;

	// store ports
	logic               wr_en;
	logic [AW-1:0]      rd_addr;
	logic [COORD_W-1:0] rd_x, rd_y;

	// combinational helpers
	logic               in_xfer;
	logic               store_full;
	logic               out_free;
	logic [CW-1:0]      nxt_cnt;
	logic [AW-1:0]      nxt_idx;
	logic               idx_last;
	logic               emit_last;
	logic               bad_set;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	// sequencer outputs
	logic               load_out;
	logic [STATUS_W-1:0] load_st;
	logic               load_last;
	logic               clear_set;

	assign in_xfer    = s_tvalid && s_tready;
	assign store_full = (count_q == CW'(MAX_POINTS));
	assign out_free   = !out_valid_q || m_tready;
	assign wr_en      = in_xfer && !store_full;

	// candidate starts at the index after the current vertex, wrapping
	assign nxt_cnt  = CW'(cur_idx_q) + CW'(1);
	assign nxt_idx  = (nxt_cnt == count_q) ? '0 : nxt_cnt[AW-1:0];
	assign idx_last = ((idx_q + CW'(1)) == count_q);

	// walk ends on return to the start or after the maximum vertex count
	assign emit_last = (cand_idx_q == start_idx_q) ||
	                   (emit_cnt_q == CW'(MAX_POINTS - 1));

	assign bad_set = overflow_q || (count_q < CW'(3));

	assign rd_addr = (state_q == S_CAND_RD) ? nxt_idx : idx_q[AW-1:0];

	// shared multiplier: first (xi-xc)*(yk-yc), then (yi-yc)*(xk-xc)
	assign mul_a = (state_q == S_PT_MUL2) ? dyi_q : dxi_q;
	assign mul_b = (state_q == S_PT_MUL2) ? dxk_q : dyk_q;
	assign mul_p = mul_a * mul_b;

	gwch_ram #(
		.WIDTH (COORD_W),
		.DEPTH (MAX_POINTS)
	) u_x_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (s_tdata[15:0]),
		.raddr (rd_addr),
		.rdata (rd_x)
	);

	gwch_ram #(
		.WIDTH (COORD_W),
		.DEPTH (MAX_POINTS)
	) u_y_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (s_tdata[31:16]),
		.raddr (rd_addr),
		.rdata (rd_y)
	);

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		load_st   = ST_OK;
		load_last = 1'b0;
		clear_set = 1'b0;
		s_tready  = 1'b0;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (bad_set) begin
					// error result: zero coordinates, single transfer
					if (out_free) begin
						load_out  = 1'b1;
						load_st   = overflow_q ? ST_DROP : ST_FEW;
						load_last = 1'b1;
						clear_set = 1'b1;
						state_d   = S_LOAD;
					end
				end else begin
					state_d = S_LM_RD;
				end
			end
			S_LM_RD:   state_d = S_LM_CMP;
			S_LM_CMP:  state_d = idx_last ? S_CAND_RD : S_LM_RD;
			S_CAND_RD: state_d = S_CAND_LD;
			S_CAND_LD: state_d = S_PT_RD;
			S_PT_RD:   state_d = S_PT_DIFF;
			S_PT_DIFF: state_d = S_PT_MUL1;
			S_PT_MUL1: state_d = S_PT_MUL2;
			S_PT_MUL2: state_d = S_PT_CMP;
			S_PT_CMP:  state_d = idx_last ? S_EMIT : S_PT_RD;
			S_EMIT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_st   = ST_OK;
					load_last = emit_last;
					if (emit_last) begin
						clear_set = 1'b1;
						state_d   = S_LOAD;
					end else begin
						state_d = S_CAND_RD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			idx_q       <= '0;
			emit_cnt_q  <= '0;
			start_idx_q <= '0;
			cur_idx_q   <= '0;
			cand_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (store_full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (clear_set) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end

			case (state_q)
				S_DECIDE: begin
					idx_q <= '0;
				end
				S_LM_CMP: begin
					// ties on x go to the later point
					if (idx_q == '0 || rd_x <= cur_x_q) begin
						start_idx_q <= idx_q[AW-1:0];
						cur_idx_q   <= idx_q[AW-1:0];
					end
					idx_q      <= idx_last ? '0 : idx_q + CW'(1);
					emit_cnt_q <= '0;
				end
				S_CAND_RD: begin
					cand_idx_q <= nxt_idx;
				end
				S_CAND_LD: begin
					idx_q <= '0;
				end
				S_PT_CMP: begin
					if (p1_q < prod_q) begin
						cand_idx_q <= idx_q[AW-1:0];
					end
					idx_q <= idx_last ? '0 : idx_q + CW'(1);
				end
				S_EMIT: begin
					if (out_free && !emit_last) begin
						cur_idx_q  <= cand_idx_q;
						emit_cnt_q <= emit_cnt_q + CW'(1);
					end
				end
				default: begin
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LM_CMP: begin
				if (idx_q == '0 || rd_x <= cur_x_q) begin
					cur_x_q <= rd_x;
					cur_y_q <= rd_y;
				end
			end
			S_CAND_LD: begin
				cand_x_q <= rd_x;
				cand_y_q <= rd_y;
			end
			S_PT_DIFF: begin
				pt_x_q <= rd_x;
				pt_y_q <= rd_y;
				dxi_q  <= $signed({1'b0, rd_x}) - $signed({1'b0, cur_x_q});
				dyi_q  <= $signed({1'b0, rd_y}) - $signed({1'b0, cur_y_q});
				dxk_q  <= $signed({1'b0, cand_x_q}) - $signed({1'b0, cur_x_q});
				dyk_q  <= $signed({1'b0, cand_y_q}) - $signed({1'b0, cur_y_q});
			end
			S_PT_MUL1: begin
				prod_q <= mul_p;
			end
			S_PT_MUL2: begin
				p1_q   <= prod_q;
				prod_q <= mul_p;
			end
			S_PT_CMP: begin
				// strictly counter-clockwise point replaces the candidate
				if (p1_q < prod_q) begin
					cand_x_q <= pt_x_q;
					cand_y_q <= pt_y_q;
				end
			end
			S_EMIT: begin
				if (out_free && !emit_last) begin
					cur_x_q <= cand_x_q;
					cur_y_q <= cand_y_q;
				end
			end
			default: begin
			end
		endcase

		if (load_out) begin
			out_st_q   <= load_st;
			out_last_q <= load_last;
			if (load_st == ST_OK) begin
				out_x_q <= cur_x_q;
				out_y_q <= cur_y_q;
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

	// the point count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	// an error status is always a single, last transfer with zero coordinates
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata == '0))
		else $error("error result malformed");

	// vertex indices stay within the current set while emitting
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |->
		(CW'(cand_idx_q) < count_q && CW'(start_idx_q) < count_q))
		else $error("hull index outside point set");

	// handing over the last vertex returns to loading with an empty set
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && emit_last) |=>
		(state_q == S_LOAD && count_q == '0 && !overflow_q))
		else $error("run did not close cleanly");

endmodule

// ===== sv/gwch_ram.sv =====
// ----------------------------------------------------------------------------
// gwch_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gwch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== bench/gift_wrap_convex_hull_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gift_wrap_convex_hull_top_tb
// self-checking bench for the jarvis march hull engine: point sets go in on
// the slave stream with random gaps, hull vertices are checked on the master
// stream against a local hull walk held in a small scoreboard
// ----------------------------------------------------------------------------
module gift_wrap_convex_hull_top_tb;

	import gwch_pkg::*;

	localparam int MAX_PTS     = 32;
	localparam int N_ITEMS     = 370;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_WAIT  = 200;
	localparam longint LIMIT   = 3000000;

	// how the coordinates of one point set are chosen
	typedef enum int {
		PT_FULL,
		PT_TINY,
		PT_EDGE,
		PT_LINE,
		PT_SAME
	} pt_mode_t;

	// one hull vertex as seen on the master stream
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [1:0]  st;
		logic        last;
	} vertex_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] x_coord, [31:16] y_coord
	logic        s_tlast;   // final_point
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] hull_x, [31:16] hull_y
	logic [1:0]  m_tuser;   // [1:0] status
	logic        m_tlast;   // last_of_run

	// scoreboard: keeps its own copy of the point store and the queue of
	// hull vertices still owed by the block
	class hull_scoreboard;
		bit [15:0]   pts_x [MAX_PTS];
		bit [15:0]   pts_y [MAX_PTS];
		int unsigned n_held;
		bit          dropped;
		vertex_t     vertex_q [$];
		int unsigned n_errors, n_results, n_points, n_sets;
		int unsigned n_few, n_drop, n_capped;

		task report(string msg);
			n_errors++;
			if (n_errors <= 50)
				$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		// true when point i lies strictly counter-clockwise of c->k
		function bit turns_left(int unsigned c, int unsigned i, int unsigned k);
			longint cx, cy, ix, iy, kx, ky;
			cx = pts_x[c];
			cy = pts_y[c];
			ix = pts_x[i];
			iy = pts_y[i];
			kx = pts_x[k];
			ky = pts_y[k];
			return ((ix - cx) * (ky - cy) - (iy - cy) * (kx - cx)) < 0;
		endfunction

		function void push_vertex(bit [15:0] x, bit [15:0] y, logic [1:0] st, bit last);
			vertex_t v;
			v.x    = x;
			v.y    = y;
			v.st   = st;
			v.last = last;
			vertex_q.insert(vertex_q.size(), v);
		endfunction

		// walk the hull of the held set and queue its vertices
		function void wrap_hull();
			int unsigned start, cur, cand, emitted;
			if (dropped) begin
				push_vertex(16'h0, 16'h0, ST_DROP, 1'b1);
				n_drop++;
			end else if (n_held < 3) begin
				push_vertex(16'h0, 16'h0, ST_FEW, 1'b1);
				n_few++;
			end else begin
				// leftmost point, ties go to the highest index
				start = 0;
				for (int unsigned i = 0; i < n_held; i++)
					if (pts_x[i] <= pts_x[start])
						start = i;
				cur     = start;
				emitted = 0;
				do begin
					push_vertex(pts_x[cur], pts_y[cur], ST_OK, 1'b0);
					emitted++;
					cand = (cur + 1) % n_held;
					for (int unsigned i = 0; i < n_held; i++)
						if (turns_left(cur, i, cand))
							cand = i;
					cur = cand;
				end while (cur != start && emitted < MAX_PTS);
				if (cur != start)
					n_capped++;
				vertex_q[vertex_q.size() - 1].last = 1'b1;
			end
		endfunction

		task note_point(bit [15:0] x, bit [15:0] y, bit fin);
			n_points++;
			if (n_held < MAX_PTS) begin
				pts_x[n_held] = x;
				pts_y[n_held] = y;
				n_held++;
			end else begin
				dropped = 1'b1;
			end
			if (fin) begin
				wrap_hull();
				n_sets++;
				n_held  = 0;
				dropped = 1'b0;
			end
		endtask

		task check_result(vertex_t got);
			vertex_t want;
			n_results++;
			if (vertex_q.size() == 0) begin
				report($sformatf("unexpected vertex x=%h y=%h st=%0d last=%0b",
					got.x, got.y, got.st, got.last));
			end else begin
				want = vertex_q.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.st !== want.st ||
						got.last !== want.last)
					report($sformatf({"vertex %0d: got x=%h y=%h st=%0d last=%0b, ",
						"want x=%h y=%h st=%0d last=%0b"},
						n_results, got.x, got.y, got.st, got.last,
						want.x, want.y, want.st, want.last));
			end
		endtask

		function int unsigned pending();
			return vertex_q.size();
		endfunction

		task close();
			if (vertex_q.size() != 0)
				report($sformatf("%0d hull vertices never arrived", vertex_q.size()));
		endtask
	endclass

	hull_scoreboard sb;
	bit             hold_req;
	int unsigned    n_holds;
	bit             no_gaps;
	longint         cycles;

	gift_wrap_convex_hull_top #(
		.MAX_POINTS(MAX_PTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a run that hangs ends here
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("gift_wrap_convex_hull_top: mismatch");
		$finish;
	end

	// every accepted vertex transfer goes straight to the scoreboard
	always @(posedge clk) begin
		vertex_t got;
		if (m_tvalid && m_tready) begin
			got.x    = m_tdata[15:0];
			got.y    = m_tdata[31:16];
			got.st   = m_tuser;
			got.last = m_tlast;
			sb.check_result(got);
		end
	end

	// receiver: random ready pattern, plus a long hold-off on request
	initial begin
		bit rdy;
		int unsigned len, r;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req = 1'b0;
				n_holds++;
				rdy = 1'b0;
				len = HOLD_CYCLES;
			end else if (r < 50) begin
				rdy = 1'b1;
				len = $urandom_range(1, 8);
			end else if (r < 80) begin
				rdy = 1'b0;
				len = $urandom_range(1, 3);
			end else if (r < 90) begin
				// stretch with no back-pressure at all
				rdy = 1'b1;
				len = $urandom_range(20, 60);
			end else begin
				rdy = 1'b0;
				len = $urandom_range(10, 40);
			end
			m_tready <= rdy;
			repeat (len) @(posedge clk);
		end
	end

	// offer one point, wait for its transfer, then maybe idle a while
	task send_point(bit [15:0] x, bit [15:0] y, bit fin);
		int unsigned r, gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_point(x, y, fin);
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender stands back until every owed vertex has come out
	task wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function bit [15:0] pick_coord(pt_mode_t mode);
		int unsigned r;
		r = $urandom_range(0, 2);
		case (mode)
			PT_TINY: begin
				return 16'($urandom_range(0, 3));
			end
			PT_EDGE: begin
				if (r == 0)
					return 16'h0000;
				else if (r == 1)
					return 16'hFFFF;
				else
					return 16'($urandom_range(0, 65535));
			end
			default: begin
				return 16'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// one whole point set, the last point closes it
	task send_set(int unsigned n, pt_mode_t mode);
		bit [15:0] x, y, x0, y0, dx, dy;
		int unsigned k;
		x0 = pick_coord(PT_FULL);
		y0 = pick_coord(PT_FULL);
		dx = 16'($urandom_range(0, 40));
		dy = 16'($urandom_range(0, 40));
		for (int unsigned i = 0; i < n; i++) begin
			case (mode)
				PT_LINE: begin
					// points on one line, in shuffled order, wrap allowed
					k = $urandom_range(0, 20);
					x = x0 + 16'(k) * dx;
					y = y0 + 16'(k) * dy;
				end
				PT_SAME: begin
					x = x0;
					y = y0;
				end
				default: begin
					x = pick_coord(mode);
					y = pick_coord(mode);
				end
			endcase
			send_point(x, y, i == n - 1);
		end
	endtask

	initial begin
		int unsigned r, n, set_no;
		pt_mode_t mode;
		sb       = new();
		hold_req = 1'b0;
		n_holds  = 0;
		no_gaps  = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets
		// square on the coordinate extremes, two leftmost points tie
		send_point(16'h0000, 16'h0000, 1'b0);
		send_point(16'hFFFF, 16'h0000, 1'b0);
		send_point(16'hFFFF, 16'hFFFF, 1'b0);
		send_point(16'h0000, 16'hFFFF, 1'b1);
		// lone point, then a pair: too few for a hull
		send_point(16'hFFFF, 16'hFFFF, 1'b1);
		send_point(16'h0000, 16'h0000, 1'b0);
		send_point(16'hFFFF, 16'hFFFF, 1'b1);
		// collinear points
		send_point(16'd5, 16'd5, 1'b0);
		send_point(16'd10, 16'd10, 1'b0);
		send_point(16'd15, 16'd15, 1'b1);
		// duplicates only
		send_point(16'd7, 16'd7, 1'b0);
		send_point(16'd7, 16'd7, 1'b0);
		send_point(16'd7, 16'd7, 1'b1);
		// leftmost tie away from index 0
		send_point(16'd0, 16'd100, 1'b0);
		send_point(16'd50, 16'd0, 1'b0);
		send_point(16'd0, 16'd50, 1'b0);
		send_point(16'd50, 16'd200, 1'b1);
		// interior point that must not show up
		send_point(16'd0, 16'd0, 1'b0);
		send_point(16'd100, 16'd0, 1'b0);
		send_point(16'd50, 16'd20, 1'b0);
		send_point(16'd50, 16'd100, 1'b1);
		// alternating bit patterns
		send_point(16'hAAAA, 16'h5555, 1'b0);
		send_point(16'h5555, 16'hAAAA, 1'b0);
		send_point(16'hFFFF, 16'h0000, 1'b1);

		// random sets: mostly small ones, a few full or overflowing
		set_no = 0;
		while (sb.n_points < N_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				n = $urandom_range(1, 2);
			else if (r < 14)
				n = $urandom_range(MAX_PTS + 1, MAX_PTS + 4);
			else if (r < 22)
				n = $urandom_range(9, MAX_PTS);
			else
				n = $urandom_range(3, 8);
			r = $urandom_range(0, 99);
			if (r < 50)
				mode = PT_FULL;
			else if (r < 65)
				mode = PT_TINY;
			else if (r < 80)
				mode = PT_EDGE;
			else if (r < 92)
				mode = PT_LINE;
			else
				mode = PT_SAME;
			no_gaps = ($urandom_range(0, 3) == 0);
			send_set(n, mode);
			set_no++;
			// long receiver hold-off while the next set is already on offer
			if (set_no == 6 || set_no == 30)
				hold_req = 1'b1;
			if (set_no == 15 || set_no == 45)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		sb.close();
		$display("run covered %0d points in %0d sets, %0d vertices checked",
			sb.n_points, sb.n_sets, sb.n_results);
		$display("short sets %0d, overflow sets %0d, capped walks %0d, long hold-offs %0d",
			sb.n_few, sb.n_drop, sb.n_capped, n_holds);
		if (sb.n_errors == 0)
			$display("gift_wrap_convex_hull_top: match");
		else
			$display("gift_wrap_convex_hull_top: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
sv/gwch_pkg.sv
sv/gwch_ram.sv
sv/gift_wrap_convex_hull_top.sv
bench/gift_wrap_convex_hull_top_tb.sv
